/* sv/tile_pattern_color_encoder_top_macros.svh */
// Assertion macros for the tile pattern/color encoder.
// Used by the top level only; empty when SYNTHESIS is defined.
`ifndef TILE_PATTERN_COLOR_ENCODER_TOP_MACROS_SVH
`define TILE_PATTERN_COLOR_ENCODER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define TPCE_ASSERT_IMPL(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define TPCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TPCE_ASSERT_IMPL(lbl, clk, rst_n, prop)
`define TPCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* sv/tpce_pkg.sv */
// Shared types and constants for the tile pattern/color encoder.
// No dependencies.
`default_nettype none
package tpce_pkg;

    localparam int CELLS = 7;

    localparam logic [13:0] NAME_BASE      = 14'h1800;
    localparam logic [13:0] PAT_TABLE_BASE = 14'h0000;
    localparam logic [13:0] CLR_TABLE_BASE = 14'h2000;
    localparam logic [13:0] THIRD_STRIDE   = 14'h0800;
    localparam logic [7:0]  FRAME_ROWS     = 8'd192;
    localparam logic [3:0]  NIBBLE_MASK    = 4'h0F;

    typedef struct packed {
        logic [3:0] color_index;
        logic       frame_start;
    } pixel_t;

    typedef struct packed {
        logic [13:0] vram_address;
        logic [7:0]  vram_data;
        logic        last_write;
    } vram_write_t;

    typedef enum logic [1:0] {
        STEP_NAME,
        STEP_PATTERN,
        STEP_COLOR
    } step_t;

    // One finished run of eight pixels, waiting to be written out.
    typedef struct packed {
        logic [4:0] tx;
        logic [4:0] ty;
        logic [2:0] ry;
        logic [7:0] pattern;
        logic [3:0] fg;
        logic [3:0] bg;
    } job_t;

    typedef struct packed {
        logic slot_free;
        logic busy;
    } writer_status_t;

endpackage
`default_nettype wire

/* sv/tpce_cell.sv */
// One cell of the run shift chain: holds one color index and compares it
// against the run maximum. Depends on nothing.
`default_nettype none
module tpce_cell (
    input  wire logic       aclk,
    input  wire logic       shift_en,
    input  wire logic [3:0] idx_in,
    input  wire logic [3:0] max_cmp,
    output logic      [3:0] idx_out,
    output logic            match
);

    logic [3:0] idx_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            idx_reg <= idx_in;
        end
    end

    assign idx_out = idx_reg;
    assign match   = (idx_reg == max_cmp);

endmodule
`default_nettype wire

/* sv/tpce_writer.sv */
// Job register and write sequencer: turns one finished run into two or
// three video memory writes. Depends on tpce_pkg.
`default_nettype none
module tpce_writer (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    load,
    input  wire tpce_pkg::job_t          job_in,
    output tpce_pkg::writer_status_t     status,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output tpce_pkg::vram_write_t        m_data
);

    tpce_pkg::job_t  job_reg;
    tpce_pkg::step_t step_reg;
    logic            valid_reg;
    logic            finish;
    logic [7:0]      name_idx;
    logic [13:0]     third_off;
    logic [13:0]     tile_off;

    assign finish           = valid_reg && m_ready && (step_reg == tpce_pkg::STEP_COLOR);
    assign status.slot_free = !valid_reg || finish;
    assign status.busy      = valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            step_reg  <= tpce_pkg::STEP_NAME;
        end else if (load) begin
            valid_reg <= 1'b1;
            job_reg   <= job_in;
            step_reg  <= (job_in.ry == 3'd0) ? tpce_pkg::STEP_NAME : tpce_pkg::STEP_PATTERN;
        end else if (valid_reg && m_ready) begin
            unique case (step_reg)
                tpce_pkg::STEP_NAME:    step_reg  <= tpce_pkg::STEP_PATTERN;
                tpce_pkg::STEP_PATTERN: step_reg  <= tpce_pkg::STEP_COLOR;
                tpce_pkg::STEP_COLOR:   valid_reg <= 1'b0;
                default:                valid_reg <= 1'b0;
            endcase
        end
    end

    assign name_idx  = {job_reg.ty[2:0], job_reg.tx};
    // Thirds of the screen are 2 KiB apart; ty never exceeds 23
    assign third_off = tpce_pkg::THIRD_STRIDE * {12'd0, job_reg.ty[4:3]};
    assign tile_off  = {3'd0, name_idx, job_reg.ry};

    always_comb begin
        m_data.last_write = 1'b0;
        unique case (step_reg)
            tpce_pkg::STEP_NAME: begin
                m_data.vram_address = tpce_pkg::NAME_BASE
                                    + {4'd0, job_reg.ty, job_reg.tx};
                m_data.vram_data    = name_idx;
            end
            tpce_pkg::STEP_PATTERN: begin
                m_data.vram_address = tpce_pkg::PAT_TABLE_BASE + third_off + tile_off;
                m_data.vram_data    = job_reg.pattern;
            end
            default: begin
                m_data.vram_address = tpce_pkg::CLR_TABLE_BASE + third_off + tile_off;
                m_data.vram_data    = {job_reg.fg, job_reg.bg};
                m_data.last_write   = 1'b1;
            end
        endcase
    end

    assign m_valid = valid_reg;

endmodule
`default_nettype wire

/* sv/tile_pattern_color_encoder_top.sv */
// Tile pattern/color encoder, top level.
// Depends on tpce_pkg, tpce_cell, tpce_writer and the assertion macro header.
//
// Takes color indices in raster order over a 256x192 frame and,
// at the end of every run of eight pixels, emits the name entry (first line
// of a tile only), the pattern byte and the color byte, the last flagged by
// last_write. Pixels are accepted one per clock while s_ready is high; the
// run sits in a chain of seven index cells plus the incoming pixel. A
// finished run is held in a single job register and drained one write per
// cycle while m_ready is high; the input never stalls while the output
// keeps up. The input stalls only on a run-ending pixel while the previous
// job is still draining. The first write is presented in the cycle after
// the eighth pixel is accepted. No clearing pass after reset.
`default_nettype none
`include "tile_pattern_color_encoder_top_macros.svh"
module tile_pattern_color_encoder_top (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire tpce_pkg::pixel_t      s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output tpce_pkg::vram_write_t      m_data
);

    localparam int N = tpce_pkg::CELLS;

    logic [7:0] column_reg, column_next;
    logic [7:0] row_reg, row_next;
    logic [3:0] run_min_reg, run_min_next;
    logic [3:0] run_max_reg, run_max_next;

    logic [7:0] column_eff, row_eff;
    logic [3:0] min_eff, max_eff, min_new, max_new, idx;
    logic       ends_run, accept, load;

    logic [3:0] chain [N+1];
    logic [N-1:0] match;

    tpce_pkg::job_t           job;
    tpce_pkg::writer_status_t wstat;

    assign idx        = s_data.color_index;
    assign column_eff = s_data.frame_start ? 8'd0 : column_reg;
    assign row_eff    = s_data.frame_start ? 8'd0 : row_reg;
    assign min_eff    = s_data.frame_start ? 4'd15 : run_min_reg;
    assign max_eff    = s_data.frame_start ? 4'd0 : run_max_reg;
    assign min_new    = (idx < min_eff) ? idx : min_eff;
    assign max_new    = (idx > max_eff) ? idx : max_eff;
    assign ends_run   = (column_eff[2:0] == 3'd7);

    assign s_ready = !ends_run || wstat.slot_free;
    assign accept  = s_valid && s_ready;
    assign load    = accept && ends_run;

    // Shift chain: chain[0] is the incoming pixel; cell 0 holds the newest stored one
    assign chain[0] = idx;
    for (genvar g = 0; g < N; g++) begin : g_cells
        tpce_cell u_cell (
            .aclk     (aclk),
            .shift_en (accept),
            .idx_in   (chain[g]),
            .max_cmp  (max_new),
            .idx_out  (chain[g+1]),
            .match    (match[g])
        );
    end

    assign job.tx      = column_eff[7:3];
    assign job.ty      = row_eff[7:3];
    assign job.ry      = row_eff[2:0];
    // Leftmost pixel sits in the last cell and lands in the MSB
    assign job.pattern = {match, (idx == max_new)};
    assign job.fg      = (max_new + 4'd1) & tpce_pkg::NIBBLE_MASK;
    assign job.bg      = (min_new + 4'd1) & tpce_pkg::NIBBLE_MASK;

    always_comb begin
        column_next  = column_eff + 8'd1;
        row_next     = row_eff;
        if (column_next == 8'd0) begin
            row_next = (row_eff + 8'd1 >= tpce_pkg::FRAME_ROWS) ? 8'd0 : row_eff + 8'd1;
        end
        run_min_next = ends_run ? 4'd15 : min_new;
        run_max_next = ends_run ? 4'd0 : max_new;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg  <= 8'd0;
            row_reg     <= 8'd0;
            run_min_reg <= 4'd15;
            run_max_reg <= 4'd0;
        end else if (accept) begin
            column_reg  <= column_next;
            row_reg     <= row_next;
            run_min_reg <= run_min_next;
            run_max_reg <= run_max_next;
        end
    end

    tpce_writer u_writer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (load),
        .job_in  (job),
        .status  (wstat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    `TPCE_ASSERT_IMPL(a_last_in_color, aclk, aresetn,
        (m_valid && m_data.last_write) |-> m_data.vram_address[13])
    `TPCE_ASSERT_IMPL(a_nonlast_below_color, aclk, aresetn,
        (m_valid && !m_data.last_write) |-> !m_data.vram_address[13])
    `TPCE_ASSERT_NEXT(a_run_end_loads, aclk, aresetn, load, m_valid && wstat.busy)
    `TPCE_ASSERT_IMPL(a_name_data, aclk, aresetn,
        (m_valid && m_data.vram_address[13:11] == 3'b011)
        |-> (m_data.vram_data == m_data.vram_address[7:0]))

endmodule
`default_nettype wire
